// ----- design/fdl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fdl_pkg;

  localparam int GAIN_BITS    = 16;
  localparam int LEN_CFG_BITS = 19;
  localparam int CFG_DATA_BITS = LEN_CFG_BITS;
  localparam int ROUND_SHIFT  = 15;
  localparam int LEN_RESET    = 36000;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DELAY_LENGTH  = 2'd0;
  localparam cfg_idx_t REG_FEEDBACK_GAIN = 2'd1;
  localparam cfg_idx_t REG_WET_GAIN      = 2'd2;
  localparam cfg_idx_t REG_DRY_GAIN      = 2'd3;

endpackage
`default_nettype wire

// ----- design/fdl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/feedback_delay_line_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Feedback echo: one audio sample in, one sample out.
// Slave stream s_* carries input samples, master stream m_* the echoed output.
// Each sample x reads the delayed sample d at the current ring position, gives
// out = sat(round(dry*x) + d) and writes sat(round(wet*x + fb*d)) back to the
// same slot; the position then advances and wraps at the active delay length.
// Throughput: one sample per cycle while m_tready allows, set by the one read and
// one write port of the delay RAM. An accepted request passes the RAM read, the
// gain products, then sum/round/saturate into the output register.
// Configuration (cfg_we/cfg_index/cfg_data) is written while the stream is idle;
// writing delay_length may move the position back to zero.
// Reset: gains 0, delay length 36000 (clamped to DEPTH), position 0, and the
// delay line reads as all zero; a high-water mark over the written prefix of the
// RAM stands in for clearing it, so samples are taken right after reset.
// While a result waits on m_tready the whole pipeline holds and s_tready drops,
// so no request is lost; the output register keeps its result until it is taken.
module feedback_delay_line_top #(
  parameter int DEPTH       = 262144,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [SAMPLE_BITS-1:0] in_sample, rest zero padding
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [SAMPLE_BITS-1:0] out_sample, rest zero padding
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
  input  wire logic                               cfg_we,
  input  wire fdl_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [fdl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fdl_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PW  = $clog2(DEPTH);
  localparam int LW  = PW + 1;
  localparam int PRW = SB + GAIN_BITS + 1;
  localparam int W2  = SB + GAIN_BITS + 2;
  localparam int LEN_RESET_CLAMPED = (LEN_RESET > DEPTH) ? DEPTH : LEN_RESET;

  localparam logic signed [W2-1:0] RND  = W2'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [W2-1:0] SMAX = {{(W2-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [W2-1:0] SMIN = {{(W2-SB+1){1'b1}}, {(SB-1){1'b0}}};

  // configuration
  logic [LW-1:0]        active_len;
  logic [GAIN_BITS-1:0] feedback_gain;
  logic [GAIN_BITS-1:0] wet_gain;
  logic [GAIN_BITS-1:0] dry_gain;
  logic [LW-1:0]        len_clamped;

  // ring state
  logic [PW-1:0] position;
  logic [PW-1:0] position_next;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] fill;

  // pipeline
  logic                 en;
  logic                 accept;
  logic                 s1_valid;
  logic signed [SB-1:0] s1_x;
  logic [PW-1:0]        s1_pos;
  logic [SB-1:0]        rdata;
  logic signed [SB-1:0] d_resolved;

  logic                  s2_valid;
  logic [PW-1:0]         s2_pos;
  logic signed [SB-1:0]  s2_d;
  logic signed [PRW-1:0] s2_pdry;
  logic signed [PRW-1:0] s2_pwet;

  logic signed [PRW-1:0] p_fb;
  logic signed [W2-1:0]  w_sum;
  logic signed [W2-1:0]  w_rnd;
  logic signed [W2-1:0]  y_rnd;
  logic signed [W2-1:0]  y_sum;
  logic signed [SB-1:0]  w_sat;
  logic signed [SB-1:0]  y_sat;

  logic                 lw_valid;
  logic [PW-1:0]        lw_pos;
  logic signed [SB-1:0] lw_data;

  logic [SB-1:0] out_sample;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  always_comb begin
    if (cfg_data == '0) begin
      len_clamped = LW'(1);
    end else if (32'(cfg_data) > 32'(DEPTH)) begin
      len_clamped = LW'(DEPTH);
    end else begin
      len_clamped = LW'(cfg_data);
    end
  end

  always_comb begin
    pos_inc = {1'b0, position} + LW'(1);
    if (pos_inc >= active_len) begin
      position_next = '0;
    end else begin
      position_next = pos_inc[PW-1:0];
    end
  end

  fdl_ram #(
    .WIDTH(SB),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (s2_valid && en),
    .waddr(s2_pos),
    .wdata(w_sat),
    .re   (en),
    .raddr(position),
    .rdata(rdata)
  );

  // d comes from the newest writer of the slot: the item one ahead (still being
  // computed), the item written as this one was read, or the RAM if the slot
  // lies in the written prefix; otherwise the line still holds its reset zero.
  always_comb begin
    if (s2_valid && s2_pos == s1_pos) begin
      d_resolved = w_sat;
    end else if (lw_valid && lw_pos == s1_pos) begin
      d_resolved = lw_data;
    end else if ({1'b0, s1_pos} < fill) begin
      d_resolved = $signed(rdata);
    end else begin
      d_resolved = '0;
    end
  end

  always_comb begin
    p_fb  = $signed({1'b0, feedback_gain}) * s2_d;
    w_sum = W2'(s2_pwet) + W2'(p_fb);
    w_rnd = (w_sum + RND) >>> ROUND_SHIFT;
    y_rnd = (W2'(s2_pdry) + RND) >>> ROUND_SHIFT;
    y_sum = y_rnd + W2'(s2_d);
    if (w_rnd > SMAX) begin
      w_sat = SMAX[SB-1:0];
    end else if (w_rnd < SMIN) begin
      w_sat = SMIN[SB-1:0];
    end else begin
      w_sat = w_rnd[SB-1:0];
    end
    if (y_sum > SMAX) begin
      y_sat = SMAX[SB-1:0];
    end else if (y_sum < SMIN) begin
      y_sat = SMIN[SB-1:0];
    end else begin
      y_sat = y_sum[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_len    <= LW'(LEN_RESET_CLAMPED);
      feedback_gain <= '0;
      wet_gain      <= '0;
      dry_gain      <= '0;
      position      <= '0;
      fill          <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      lw_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DELAY_LENGTH: begin
            active_len <= len_clamped;
            if ({1'b0, position} >= len_clamped) begin
              position <= '0;
            end
          end
          REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[GAIN_BITS-1:0];
          REG_WET_GAIN:      wet_gain      <= cfg_data[GAIN_BITS-1:0];
          REG_DRY_GAIN:      dry_gain      <= cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end else if (accept) begin
        position <= position_next;
      end
      if (en) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
        lw_valid <= s2_valid;
        m_tvalid <= s2_valid;
        // writes only ever extend the prefix starting at slot zero
        if (s2_valid && {1'b0, s2_pos} == fill) begin
          fill <= fill + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= $signed(s_tdata[SB-1:0]);
      s1_pos  <= position;
      s2_pos  <= s1_pos;
      s2_d    <= d_resolved;
      s2_pdry <= $signed({1'b0, dry_gain}) * s1_x;
      s2_pwet <= $signed({1'b0, wet_gain}) * s1_x;
      lw_pos  <= s2_pos;
      lw_data <= w_sat;
      out_sample <= y_sat;
    end
  end

  assign m_tdata = TDW'(out_sample);

endmodule
`default_nettype wire
